@@ src/cal_pkg.sv @@
`timescale 1ns / 1ps

package cal_pkg;

  // word and field widths of the transactions
  localparam int WORD_W      = 32;
  localparam int POS_W       = 4;
  localparam int COUNT_W     = 5;
  localparam int CAPACITY_DEF = 16;

  // request operations
  typedef enum logic [2:0] {
    OP_BEGIN      = 3'd0,
    OP_END        = 3'd1,
    OP_NEXT       = 3'd2,
    OP_PRIOR      = 3'd3,
    OP_INS_BEFORE = 3'd4,
    OP_INS_AFTER  = 3'd5,
    OP_REMOVE     = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UP,
    ST_DOWN,
    ST_DRAIN,
    ST_INS,
    ST_FETCH,
    ST_LOAD
  } state_t;

  typedef struct packed {
    op_t                      kind;
    logic signed [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic                     ok;
    logic signed [WORD_W-1:0] current_word;
    logic [POS_W-1:0]         cursor_pos;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_empty;
    logic                     is_full;
  } rsp_t;

endpackage

@@ src/cursor_array_list_unit.sv @@
`timescale 1ns / 1ps

// Ordered list of signed 32-bit words with a cursor, held in one memory
// with a write port and a registered read port.
// Requests arrive on req (req_valid/req_ready); each request gives exactly
// one result on rsp (rsp_valid/rsp_ready). One request is worked on at a
// time: req_ready is high only while the sequencer is idle.
// Cursor moves, clear and refused requests pass through the fetch and
// load steps to a valid result. Insert and remove first shift the entries
// from the insert point or after the cursor (up to CAPACITY - 1): the shift
// moves one entry per cycle through the memory, reading one index while
// writing the previous one back. Insert at the end or into an empty list
// shifts nothing and writes the word straight into place.
// The result sits in an output register, so a new request is accepted
// while the previous result still waits; if the receiver stalls, the next
// result is held back in the final load step until the register is free.
// Reset empties the list (count and cursor zero) and drops any pending
// result; memory contents are left as they are and are only read below
// the count.
module cursor_array_list_unit
  import cal_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = AW + 1;

  // entry memory
  logic [WORD_W-1:0] mem [CAPACITY];
  logic [WORD_W-1:0] rdata;
  logic              re;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [WORD_W-1:0] wdata;

  // control registers
  state_t            state, state_next;
  logic [CW-1:0]     count, count_next;
  logic [AW-1:0]     cursor, cursor_next;
  logic [AW-1:0]     pos, pos_next;
  logic [AW-1:0]     ptr, ptr_next;
  logic [AW-1:0]     last, last_next;
  logic              ins, ins_next;
  logic              pend, pend_next;
  logic [AW-1:0]     pend_dst, pend_dst_next;
  logic [WORD_W-1:0] value_r, value_next;
  logic              ok_r, ok_next;
  logic              rsp_valid_next;
  rsp_t              rsp_next;

  // derived values
  logic              has;
  logic              full;
  logic [CW-1:0]     cursor_ext;
  logic [AW-1:0]     last_idx;
  logic [CW-1:0]     ins_pos;
  logic [AW-1:0]     ptr_dec;
  logic [AW+3:0]     cursor_wide;
  logic [CW+4:0]     count_wide;

  assign has        = (count != '0);
  assign full       = (count == CW'(CAPACITY));
  assign cursor_ext = {1'b0, cursor};
  assign last_idx   = AW'(count - CW'(1));
  assign ins_pos    = cursor_ext + CW'(req.kind == OP_INS_AFTER);
  assign ptr_dec    = ptr - AW'(1);
  assign cursor_wide = {4'b0, cursor};
  assign count_wide  = {5'b0, count};

  assign req_ready = (state == ST_IDLE);

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // state and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      cursor    <= '0;
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      cursor    <= cursor_next;
      pend      <= pend_next;
      rsp_valid <= rsp_valid_next;
    end
    pos      <= pos_next;
    ptr      <= ptr_next;
    last     <= last_next;
    ins      <= ins_next;
    pend_dst <= pend_dst_next;
    value_r  <= value_next;
    ok_r     <= ok_next;
    rsp      <= rsp_next;
  end

  // sequencer: decode, shift loops, insert write, fetch of the cursor word, result load
  always_comb begin
    state_next     = state;
    count_next     = count;
    cursor_next    = cursor;
    pos_next       = pos;
    ptr_next       = ptr;
    last_next      = last;
    ins_next       = ins;
    pend_next      = 1'b0;
    pend_dst_next  = pend_dst;
    value_next     = value_r;
    ok_next        = ok_r;
    rsp_next       = rsp;
    rsp_valid_next = rsp_valid && !rsp_ready;
    re             = 1'b0;
    raddr          = cursor;
    we             = pend;
    waddr          = pend_dst;
    wdata          = rdata;

    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          value_next = req.value;
          ins_next   = 1'b0;
          ok_next    = 1'b0;
          state_next = ST_FETCH;
          case (req.kind)
            OP_BEGIN: begin
              if (has && cursor != '0) begin
                cursor_next = '0;
                ok_next     = 1'b1;
              end
            end
            OP_END: begin
              if (has && cursor != last_idx) begin
                cursor_next = last_idx;
                ok_next     = 1'b1;
              end
            end
            OP_NEXT: begin
              if (has && cursor != last_idx) begin
                cursor_next = cursor + AW'(1);
                ok_next     = 1'b1;
              end
            end
            OP_PRIOR: begin
              if (has && cursor != '0) begin
                cursor_next = cursor - AW'(1);
                ok_next     = 1'b1;
              end
            end
            OP_INS_BEFORE, OP_INS_AFTER: begin
              if (!full) begin
                ok_next    = 1'b1;
                count_next = count + CW'(1);
                if (!has) begin
                  pos_next    = '0;
                  cursor_next = '0;
                  state_next  = ST_INS;
                end else begin
                  pos_next    = AW'(ins_pos);
                  cursor_next = AW'(ins_pos);
                  if (ins_pos == count) begin
                    state_next = ST_INS;
                  end else begin
                    ptr_next   = AW'(count);
                    ins_next   = 1'b1;
                    state_next = ST_UP;
                  end
                end
              end
            end
            OP_REMOVE: begin
              if (has) begin
                ok_next    = 1'b1;
                count_next = count - CW'(1);
                if (cursor_ext + CW'(1) >= count) begin
                  cursor_next = '0;
                end else begin
                  ptr_next   = cursor + AW'(1);
                  last_next  = last_idx;
                  state_next = ST_DOWN;
                end
              end
            end
            default: begin
              // clear
              ok_next     = has;
              count_next  = '0;
              cursor_next = '0;
            end
          endcase
        end
      end
      // open the gap: read ptr-1, write it to ptr in the next cycle
      ST_UP: begin
        re            = 1'b1;
        raddr         = ptr_dec;
        pend_next     = 1'b1;
        pend_dst_next = ptr;
        ptr_next      = ptr_dec;
        if (ptr_dec == pos) begin
          state_next = ST_DRAIN;
        end
      end
      // close the gap: read ptr, write it to ptr-1 in the next cycle
      ST_DOWN: begin
        re            = 1'b1;
        raddr         = ptr;
        pend_next     = 1'b1;
        pend_dst_next = ptr_dec;
        ptr_next      = ptr + AW'(1);
        if (ptr == last) begin
          state_next = ST_DRAIN;
        end
      end
      // last moved entry is written back this cycle
      ST_DRAIN: begin
        state_next = ins ? ST_INS : ST_FETCH;
      end
      ST_INS: begin
        we         = 1'b1;
        waddr      = pos;
        wdata      = value_r;
        state_next = ST_FETCH;
      end
      ST_FETCH: begin
        re         = 1'b1;
        raddr      = cursor;
        state_next = ST_LOAD;
      end
      // move the result into the output register once it is free
      ST_LOAD: begin
        if (!rsp_valid || rsp_ready) begin
          rsp_next.ok           = ok_r;
          rsp_next.current_word = has ? rdata : '0;
          rsp_next.cursor_pos   = has ? cursor_wide[POS_W-1:0] : '0;
          rsp_next.entry_count  = count_wide[COUNT_W-1:0];
          rsp_next.is_empty     = !has;
          rsp_next.is_full      = full;
          rsp_valid_next        = 1'b1;
          state_next            = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_cursor_in_list: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && has |-> cursor_ext < count)
    else $error("cursor beyond last entry");

  a_cursor_empty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) && !has |-> cursor == '0)
    else $error("cursor not zero on empty list");

  a_no_pend_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) || (state == ST_FETCH) || (state == ST_LOAD) |-> !pend)
    else $error("shift write left pending");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.is_empty && rsp.is_full))
    else $error("result both empty and full");

endmodule

@@ tb/sv/tb_cursor_array_list_unit.sv @@
`timescale 1ns / 1ps

module tb_cursor_array_list_unit;
  import cal_pkg::*;

  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int RANDOM_REQS = 1350;
  localparam int PRESSURE_AT = 600;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int SETTLE      = 40;

  // receiver stall patterns
  typedef enum int {RX_STEADY, RX_COIN, RX_EVERY_FOURTH, RX_SPARSE} rx_mode_t;
  // shapes of random request sequences
  typedef enum int {SEQ_MIXED, SEQ_FILL, SEQ_DRAIN, SEQ_WALK} seq_kind_t;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready;
  rsp_t rsp;

  // tracks the list contents and the results still owed by the block
  class list_scoreboard;
    logic signed [WORD_W-1:0] words [CAPACITY];
    int unsigned count;
    int unsigned cursor;
    bit has_entries;
    rsp_t pending_results[$];
    int errors;
    int requests;
    int results;
    int refused;
    int full_hits;
    int op_seen [8];

    function new();
      count = 0;
      cursor = 0;
      has_entries = 0;
      errors = 0;
      requests = 0;
      results = 0;
      refused = 0;
      full_hits = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    // open a gap at the insert point and place the word there
    function bit insert_word(logic signed [WORD_W-1:0] w, bit after);
      int unsigned pos;
      int unsigned i;
      if (count >= CAPACITY) return 1'b0;
      if (!has_entries) begin
        words[0] = w;
        count = 1;
        cursor = 0;
        has_entries = 1'b1;
        return 1'b1;
      end
      pos = after ? cursor + 1 : cursor;
      for (i = count; i > pos; i--) words[i] = words[i-1];
      words[pos] = w;
      cursor = pos;
      count++;
      return 1'b1;
    endfunction

    // close the gap at the cursor; removing the tail sends the cursor home
    function bit remove_word();
      int unsigned i;
      if (!has_entries) return 1'b0;
      if (cursor + 1 >= count) cursor = 0;
      else for (i = cursor; i + 1 < count; i++) words[i] = words[i+1];
      count--;
      if (count == 0) begin
        has_entries = 1'b0;
        cursor = 0;
      end
      return 1'b1;
    endfunction

    function void note_request(req_t r);
      rsp_t e;
      bit ok;
      int unsigned last;
      last = has_entries ? count - 1 : 0;
      ok = 1'b0;
      requests++;
      op_seen[r.kind]++;
      case (r.kind)
        OP_BEGIN: if (has_entries && cursor != 0) begin
          cursor = 0;
          ok = 1'b1;
        end
        OP_END: if (has_entries && cursor != last) begin
          cursor = last;
          ok = 1'b1;
        end
        OP_NEXT: if (has_entries && cursor != last) begin
          cursor++;
          ok = 1'b1;
        end
        OP_PRIOR: if (has_entries && cursor != 0) begin
          cursor--;
          ok = 1'b1;
        end
        OP_INS_BEFORE: ok = insert_word(r.value, 1'b0);
        OP_INS_AFTER:  ok = insert_word(r.value, 1'b1);
        OP_REMOVE:     ok = remove_word();
        default: begin
          // clear
          ok = has_entries;
          count = 0;
          cursor = 0;
          has_entries = 1'b0;
        end
      endcase
      e.ok           = ok;
      e.current_word = has_entries ? words[cursor] : '0;
      e.cursor_pos   = has_entries ? POS_W'(cursor) : '0;
      e.entry_count  = COUNT_W'(count);
      e.is_empty     = !has_entries;
      e.is_full      = (count == CAPACITY);
      if (!ok) refused++;
      if (e.is_full) full_hits++;
      pending_results.push_back(e);
    endfunction

    function void compare_field(string name, longint want, longint got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(rsp_t a);
      rsp_t e;
      results++;
      if (pending_results.size() == 0) begin
        $display("%0t: result with nothing expected, actual %p", $time, a);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      compare_field("ok", e.ok, a.ok);
      compare_field("current_word", e.current_word, a.current_word);
      compare_field("cursor_pos", e.cursor_pos, a.cursor_pos);
      compare_field("entry_count", e.entry_count, a.entry_count);
      compare_field("is_empty", e.is_empty, a.is_empty);
      compare_field("is_full", e.is_full, a.is_full);
    endfunction
  endclass

  list_scoreboard sb;
  int idle_cycles;
  int issued;
  int burst_left;
  bit hold_rsp;

  cursor_array_list_unit #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // record every transaction on both channels and count quiet cycles
  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  // watchdog on a stuck handshake
  initial begin
    wait (idle_cycles >= IDLE_LIMIT);
    $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // receiver: switches between stall patterns, with one long hold-off on request
  initial begin
    rx_mode_t rx_mode;
    int stretch;
    int phase;
    bit held;
    rsp_ready = 1'b0;
    rx_mode = RX_STEADY;
    stretch = 0;
    phase = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp && !held) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        held = 1'b1;
      end else begin
        if (stretch == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 3));
          stretch = $urandom_range(20, 120);
        end
        stretch--;
        phase++;
        case (rx_mode)
          RX_STEADY:       rsp_ready <= 1'b1;
          RX_COIN:         rsp_ready <= 1'($urandom_range(0, 1));
          RX_EVERY_FOURTH: rsp_ready <= (phase % 4 == 0);
          default:         rsp_ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // random word, leaning on the extremes
  function automatic logic signed [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return {1'b1, {(WORD_W-1){1'b0}}};
      1:       return {1'b0, {(WORD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // sender: bursts of random length with random gaps between them
  task automatic offer(op_t op, logic signed [WORD_W-1:0] w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_valid <= 1'b1;
    req <= '{kind: op, value: w};
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
    issued++;
  endtask

  task automatic move_at_random();
    offer(op_t'($urandom_range(OP_BEGIN, OP_PRIOR)), $urandom);
  endtask

  task automatic insert_at_random();
    offer($urandom_range(0, 1) ? OP_INS_AFTER : OP_INS_BEFORE, pick_word());
  endtask

  task automatic run_sequence(seq_kind_t shape);
    int n;
    int r;
    case (shape)
      // enough inserts to reach full and be refused at least once
      SEQ_FILL: for (n = 0; n < CAPACITY + 1 + $urandom_range(0, 3); n++) begin
        if ($urandom_range(0, 3) == 0) move_at_random();
        insert_at_random();
      end
      // enough removes to empty the list and be refused at least once
      SEQ_DRAIN: for (n = 0; n < CAPACITY + 1 + $urandom_range(0, 2); n++) begin
        if ($urandom_range(0, 1) == 0) move_at_random();
        offer(OP_REMOVE, $urandom);
      end
      SEQ_WALK: for (n = $urandom_range(10, 30); n > 0; n--) move_at_random();
      default: for (n = $urandom_range(10, 40); n > 0; n--) begin
        r = $urandom_range(0, 99);
        if (r < 20)      offer(OP_INS_BEFORE, pick_word());
        else if (r < 42) offer(OP_INS_AFTER, pick_word());
        else if (r < 60) offer(OP_REMOVE, $urandom);
        else if (r < 68) offer(OP_BEGIN, $urandom);
        else if (r < 76) offer(OP_END, $urandom);
        else if (r < 86) offer(OP_NEXT, $urandom);
        else if (r < 96) offer(OP_PRIOR, $urandom);
        else             offer(OP_CLEAR, $urandom);
      end
    endcase
  endtask

  initial begin
    int target;
    bit pressure_done;
    int n;
    sb = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    idle_cycles = 0;
    issued = 0;
    burst_left = 0;
    hold_rsp = 1'b0;
    pressure_done = 1'b0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // refusals on an empty list
    offer(OP_BEGIN, $urandom);
    offer(OP_END, $urandom);
    offer(OP_NEXT, $urandom);
    offer(OP_PRIOR, $urandom);
    offer(OP_REMOVE, $urandom);
    offer(OP_CLEAR, $urandom);
    // first insert, moves onto the position already held, then moves to the front and the end
    offer(OP_INS_BEFORE, {1'b1, {(WORD_W-1){1'b0}}});
    offer(OP_BEGIN, $urandom);
    offer(OP_INS_AFTER, {1'b0, {(WORD_W-1){1'b1}}});
    offer(OP_NEXT, $urandom);
    offer(OP_INS_BEFORE, '0);
    offer(OP_PRIOR, $urandom);
    offer(OP_END, $urandom);
    // remove at the tail, at the head, then the only entry
    offer(OP_REMOVE, $urandom);
    offer(OP_REMOVE, $urandom);
    offer(OP_REMOVE, $urandom);
    // insert after into an empty list, then clear a populated list
    offer(OP_INS_AFTER, '1);
    offer(OP_INS_BEFORE, pick_word());
    offer(OP_CLEAR, $urandom);

    // random part, opened with a fill so the full list is reached early
    target = issued + RANDOM_REQS;
    run_sequence(SEQ_FILL);
    while (issued < target) begin
      if (!pressure_done && issued >= target - RANDOM_REQS + PRESSURE_AT) begin
        // stall the receiver while requests keep coming back to back
        hold_rsp = 1'b1;
        burst_left = 16;
        for (n = 0; n < 12; n++) insert_at_random();
        pressure_done = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1:    run_sequence(SEQ_FILL);
        2, 3:    run_sequence(SEQ_DRAIN);
        4, 5:    run_sequence(SEQ_WALK);
        default: run_sequence(SEQ_MIXED);
      endcase
    end
    req_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    $display("covered %0d requests (%0d refused) and %0d results; list full in %0d results",
             sb.requests, sb.refused, sb.results, sb.full_hits);
    $display("per operation: begin %0d end %0d next %0d prior %0d ins_before %0d",
             sb.op_seen[OP_BEGIN], sb.op_seen[OP_END], sb.op_seen[OP_NEXT],
             sb.op_seen[OP_PRIOR], sb.op_seen[OP_INS_BEFORE]);
    $display("  ins_after %0d remove %0d clear %0d",
             sb.op_seen[OP_INS_AFTER], sb.op_seen[OP_REMOVE], sb.op_seen[OP_CLEAR]);
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
